[sv/fiap_pkg.sv]
// ----------------------------------------------------------------------------
// fiap_pkg
// Shared types, constants and sector map helpers for the flash and eeprom
// programming command engine.
// ----------------------------------------------------------------------------
package fiap_pkg;

   // store geometry
   localparam int unsigned FLASH_BYTES        = 524288;
   localparam int unsigned EEPROM_BYTES       = 4096;
   localparam int unsigned SMALL_SECTOR_COUNT = 16;
   localparam int unsigned LAST_SECTOR        = 29;
   localparam int unsigned SMALL_SECTOR_SIZE  = 32'h1000;
   localparam int unsigned LARGE_SECTOR_SIZE  = 32'h8000;

   localparam int unsigned FLASH_AW = $clog2(FLASH_BYTES);
   localparam int unsigned EE_AW    = $clog2(EEPROM_BYTES);
   localparam int unsigned WALK_W   = 24;
   localparam int unsigned SEC_W    = 5;

   // register reset values
   localparam logic [31:0] PART_ID_RESET  = 32'h281D3F47;
   localparam logic [31:0] BOOT_VER_RESET = 32'h00010101;
   localparam logic [31:0] UID0_RESET     = 32'h53485452;
   localparam logic [31:0] UID1_RESET     = 32'h49482D4D;
   localparam logic [31:0] UID2_RESET     = 32'h30314600;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   typedef enum logic [3:0] {
      ACT_NOOP     = 4'd0,
      ACT_COPY     = 4'd1,
      ACT_ERASE    = 4'd2,
      ACT_BLANK    = 4'd3,
      ACT_PART_ID  = 4'd4,
      ACT_BOOT_VER = 4'd5,
      ACT_COMPARE  = 4'd6,
      ACT_UID      = 4'd7,
      ACT_EE_WRITE = 4'd8,
      ACT_EE_READ  = 4'd9
   } action_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_BAD_SECTOR = 3'd1,
      STS_NOT_BLANK  = 3'd2,
      STS_COUNT      = 3'd3,
      STS_DST        = 3'd4,
      STS_SRC        = 3'd5,
      STS_MISMATCH   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_PART_ID  = 3'd0,
      REG_BOOT_VER = 3'd1,
      REG_UID0     = 3'd2,
      REG_UID1     = 3'd3,
      REG_UID2     = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ERASE,
      ST_BLANK,
      ST_BLANK_END
   } state_type;

   typedef enum logic [1:0] {
      RSP_IMM,
      RSP_READ,
      RSP_BLANK_FAIL,
      RSP_OK
   } rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        clear_step;
      logic        stream_step;
      logic        stream_clear;
      logic        copy_wr;
      logic        ee_wr;
      logic        cmp_step;
      logic        walk_start;
      logic        erase_step;
      logic        blank_step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic range_bad;
      logic range_empty;
      logic walk_last;
      logic blank_fail;
   } stat_type;

   // first byte of a sector
   function automatic logic [WALK_W-1:0] sec_base(input logic [SEC_W-1:0] sec);
      logic [WALK_W-1:0] base;
      if (sec < SEC_W'(SMALL_SECTOR_COUNT))
         base = WALK_W'(sec) * WALK_W'(SMALL_SECTOR_SIZE);
      else
         base = WALK_W'(SMALL_SECTOR_COUNT * SMALL_SECTOR_SIZE) +
                WALK_W'(sec - SEC_W'(SMALL_SECTOR_COUNT)) * WALK_W'(LARGE_SECTOR_SIZE);
      return base;
   endfunction

   // one past the last byte of a sector, clipped to the flash
   function automatic logic [WALK_W-1:0] sec_end(input logic [SEC_W-1:0] sec);
      logic [WALK_W-1:0] e;
      e = sec_base(sec) + ((sec < SEC_W'(SMALL_SECTOR_COUNT)) ?
          WALK_W'(SMALL_SECTOR_SIZE) : WALK_W'(LARGE_SECTOR_SIZE));
      if (e > WALK_W'(FLASH_BYTES))
         e = WALK_W'(FLASH_BYTES);
      return e;
   endfunction

endpackage

[sv/fiap_ctrl.sv]
// ----------------------------------------------------------------------------
// fiap_ctrl
// Command sequencer: accepts items, steps the erase and blank check walks,
// runs the power-up clearing pass and owns the result valid flag.
// ----------------------------------------------------------------------------
module fiap_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [3:0]         req_tuser,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output fiap_pkg::cmd_type  cmd,
   input  fiap_pkg::stat_type stat
);
   import fiap_pkg::*;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   action_type act;

   assign act        = action_type'(req_tuser);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rsp_sel = RSP_IMM;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = slot_free;
            if (req_tvalid && slot_free) begin
               case (act)
                  ACT_COPY, ACT_EE_WRITE, ACT_COMPARE: begin
                     cmd.stream_step  = 1'b1;
                     cmd.copy_wr      = (act == ACT_COPY);
                     cmd.ee_wr        = (act == ACT_EE_WRITE);
                     cmd.cmp_step     = (act == ACT_COMPARE);
                     cmd.stream_clear = req_tlast;
                     cmd.rsp_load     = req_tlast;
                  end
                  ACT_EE_READ: begin
                     cmd.stream_step  = 1'b1;
                     cmd.stream_clear = req_tlast;
                     state_in         = ST_READ;
                  end
                  ACT_ERASE, ACT_BLANK: begin
                     cmd.stream_clear = 1'b1;
                     if (stat.range_bad || stat.range_empty) begin
                        cmd.rsp_load = 1'b1;
                     end else begin
                        cmd.walk_start = 1'b1;
                        state_in = (act == ACT_ERASE) ? ST_ERASE : ST_BLANK;
                     end
                  end
                  default: begin
                     cmd.stream_clear = 1'b1;
                     cmd.rsp_load     = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_READ;
            state_in     = ST_IDLE;
         end
         ST_ERASE: begin
            cmd.erase_step = 1'b1;
            if (stat.walk_last) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_OK;
               state_in     = ST_IDLE;
            end
         end
         ST_BLANK: begin
            if (stat.blank_fail) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_BLANK_FAIL;
               state_in     = ST_IDLE;
            end else begin
               cmd.blank_step = 1'b1;
               if (stat.walk_last) state_in = ST_BLANK_END;
            end
         end
         ST_BLANK_END: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = stat.blank_fail ? RSP_BLANK_FAIL : RSP_OK;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on load, dropped when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

`ifndef SYNTHESIS
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending result");
   a_read_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("read result slot busy");
   a_walk_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE || state_ff == ST_BLANK) |-> !req_tready)
      else $error("input accepted during a walk");
   a_clear_first: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == ST_CLEAR))
      else $error("clearing pass skipped after reset");
`endif

endmodule

[sv/fiap_dpath.sv]
// ----------------------------------------------------------------------------
// fiap_dpath
// Datapath: flash and eeprom memories, stream position, compare tracking,
// sector walk counter, id registers and the result register.
// ----------------------------------------------------------------------------
module fiap_dpath (
   input  logic               clock,
   input  logic               reset,
   input  fiap_pkg::cmd_type  cmd,
   output fiap_pkg::stat_type stat,
   input  logic [3:0]         req_tuser,
   input  logic [143:0]       req_tdata,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic [2:0]         rsp_tuser,
   output logic [103:0]       rsp_tdata
);
   import fiap_pkg::*;

   // input fields
   action_type  act;
   logic [31:0] offset, count, s0, s1;
   logic [7:0]  byte_a, byte_b;

   assign act    = action_type'(req_tuser);
   assign offset = req_tdata[31:0];
   assign count  = req_tdata[63:32];
   assign s0     = req_tdata[95:64];
   assign s1     = req_tdata[127:96];
   assign byte_a = req_tdata[135:128];
   assign byte_b = req_tdata[143:136];

   // id registers
   logic [31:0] part_id_ff, boot_ver_ff, uid0_ff, uid1_ff, uid2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         part_id_ff  <= PART_ID_RESET;
         boot_ver_ff <= BOOT_VER_RESET;
         uid0_ff     <= UID0_RESET;
         uid1_ff     <= UID1_RESET;
         uid2_ff     <= UID2_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_PART_ID:  part_id_ff  <= csr_data;
            REG_BOOT_VER: boot_ver_ff <= csr_data;
            REG_UID0:     uid0_ff     <= csr_data;
            REG_UID1:     uid1_ff     <= csr_data;
            REG_UID2:     uid2_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // stream state
   logic [31:0] pos_ff, pos_in, mis_off_ff, mis_off_in;
   logic        mis_seen_ff, mis_seen_in;
   logic        in_count, mis_now;

   assign in_count = pos_ff < count;
   assign mis_now  = in_count && !mis_seen_ff && (byte_a != byte_b);

   always_comb begin
      pos_in      = pos_ff;
      mis_seen_in = mis_seen_ff;
      mis_off_in  = mis_off_ff;
      if (cmd.stream_clear) begin
         pos_in      = '0;
         mis_seen_in = 1'b0;
         mis_off_in  = '0;
      end else if (cmd.stream_step) begin
         pos_in = pos_ff + 32'd1;
         if (cmd.cmp_step && mis_now) begin
            mis_seen_in = 1'b1;
            mis_off_in  = pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         mis_seen_ff <= 1'b0;
         mis_off_ff  <= '0;
      end else begin
         pos_ff      <= pos_in;
         mis_seen_ff <= mis_seen_in;
         mis_off_ff  <= mis_off_in;
      end
   end

   // range checks
   logic [32:0] span;
   logic        flash_ok, ee_ok;
   assign span     = {1'b0, offset} + {1'b0, count};
   assign flash_ok = (count != '0) && (offset < 32'(FLASH_BYTES)) &&
                     (count <= 32'(FLASH_BYTES)) && (span <= 33'(FLASH_BYTES));
   assign ee_ok    = (count != '0) && (offset < 32'(EEPROM_BYTES)) &&
                     (count <= 32'(EEPROM_BYTES)) && (span <= 33'(EEPROM_BYTES));

   logic [FLASH_AW-1:0] flash_addr;
   logic [EE_AW-1:0]    ee_addr;
   assign flash_addr = offset[FLASH_AW-1:0] + pos_ff[FLASH_AW-1:0];
   assign ee_addr    = offset[EE_AW-1:0] + pos_ff[EE_AW-1:0];

   // sector range and walk counter
   logic [SEC_W-1:0]    sec0, sec1;
   logic [WALK_W-1:0]   walk_base, walk_end;
   logic [FLASH_AW-1:0] walk_addr_ff, walk_last_ff;
   assign sec0      = s0[SEC_W-1:0];
   assign sec1      = s1[SEC_W-1:0];
   assign walk_base = sec_base(sec0);
   assign walk_end  = sec_end(sec1);

   assign stat.range_bad   = (s1 < s0) || (s1 > 32'(LAST_SECTOR));
   assign stat.range_empty = walk_base >= walk_end;
   assign stat.walk_last   = walk_addr_ff == walk_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         walk_addr_ff <= walk_base[FLASH_AW-1:0];
         walk_last_ff <= FLASH_AW'(walk_end - WALK_W'(1));
      end else if (cmd.erase_step || cmd.blank_step) begin
         walk_addr_ff <= walk_addr_ff + FLASH_AW'(1);
      end
   end

   // power-up clearing counter
   logic [FLASH_AW-1:0] clr_ff;
   assign stat.clear_last = clr_ff == FLASH_AW'(FLASH_BYTES - 1);
   always_ff @(posedge clock) begin
      if (reset)               clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + FLASH_AW'(1);
   end

   // flash memory, one write and one read port
   logic [7:0]          flash_mem [FLASH_BYTES];
   logic                fl_we;
   logic [FLASH_AW-1:0] fl_wa;
   logic [7:0]          fl_wd, fl_q_ff;
   always_comb begin
      fl_we = 1'b0;
      fl_wa = walk_addr_ff;
      fl_wd = ERASED_BYTE;
      if (cmd.clear_step) begin
         fl_we = 1'b1;
         fl_wa = clr_ff;
      end else if (cmd.erase_step) begin
         fl_we = 1'b1;
      end else if (cmd.copy_wr && flash_ok && in_count) begin
         fl_we = 1'b1;
         fl_wa = flash_addr;
         fl_wd = byte_a;
      end
   end
   always_ff @(posedge clock) begin
      if (fl_we) flash_mem[fl_wa] <= fl_wd;
      fl_q_ff <= flash_mem[walk_addr_ff];
   end

   // blank check read pipeline
   logic                rd_vld_ff;
   logic [FLASH_AW-1:0] rd_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= cmd.blank_step;
      rd_addr_ff <= walk_addr_ff;
   end
   assign stat.blank_fail = rd_vld_ff && (fl_q_ff != ERASED_BYTE);

   // eeprom memory
   logic [7:0]       ee_mem [EEPROM_BYTES];
   logic             ee_we;
   logic [EE_AW-1:0] ee_wa;
   logic [7:0]       ee_wd, ee_q_ff;
   logic             rd_ok_ff, rd_take_ff;
   always_comb begin
      ee_we = 1'b0;
      ee_wa = ee_addr;
      ee_wd = byte_a;
      if (cmd.clear_step) begin
         ee_we = clr_ff < FLASH_AW'(EEPROM_BYTES);
         ee_wa = clr_ff[EE_AW-1:0];
         ee_wd = '0;
      end else if (cmd.ee_wr && ee_ok && in_count) begin
         ee_we = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (ee_we) ee_mem[ee_wa] <= ee_wd;
      ee_q_ff    <= ee_mem[ee_addr];
      rd_ok_ff   <= ee_ok;
      rd_take_ff <= ee_ok && in_count;
   end

   // immediate result from the accepted item
   status_type  imm_sts;
   logic [31:0] imm_w1, imm_w2, imm_w3;
   always_comb begin
      imm_sts = STS_OK;
      imm_w1  = '0;
      imm_w2  = '0;
      imm_w3  = '0;
      case (act)
         ACT_COPY:     imm_sts = flash_ok ? STS_OK : STS_DST;
         ACT_EE_WRITE: imm_sts = ee_ok ? STS_OK : STS_DST;
         ACT_COMPARE: begin
            if (count == '0) begin
               imm_sts = STS_COUNT;
            end else if (mis_seen_ff || mis_now) begin
               imm_sts = STS_MISMATCH;
               imm_w1  = mis_seen_ff ? mis_off_ff : pos_ff;
            end
         end
         ACT_ERASE, ACT_BLANK: imm_sts = stat.range_bad ? STS_BAD_SECTOR : STS_OK;
         ACT_PART_ID:  imm_w1 = part_id_ff;
         ACT_BOOT_VER: imm_w1 = boot_ver_ff;
         ACT_UID: begin
            imm_w1 = uid0_ff;
            imm_w2 = uid1_ff;
            imm_w3 = uid2_ff;
         end
         default: ;
      endcase
   end

   // result register
   status_type  rsp_sts_ff;
   logic [31:0] rsp_w1_ff, rsp_w2_ff, rsp_w3_ff;
   logic [7:0]  rsp_rb_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            RSP_IMM: begin
               rsp_sts_ff <= imm_sts;
               rsp_w1_ff  <= imm_w1;
               rsp_w2_ff  <= imm_w2;
               rsp_w3_ff  <= imm_w3;
               rsp_rb_ff  <= '0;
            end
            RSP_READ: begin
               rsp_sts_ff <= rd_ok_ff ? STS_OK : STS_SRC;
               rsp_w1_ff  <= '0;
               rsp_w2_ff  <= '0;
               rsp_w3_ff  <= '0;
               rsp_rb_ff  <= rd_take_ff ? ee_q_ff : 8'd0;
            end
            RSP_BLANK_FAIL: begin
               rsp_sts_ff <= STS_NOT_BLANK;
               rsp_w1_ff  <= 32'(rd_addr_ff);
               rsp_w2_ff  <= 32'(fl_q_ff);
               rsp_w3_ff  <= '0;
               rsp_rb_ff  <= '0;
            end
            default: begin
               rsp_sts_ff <= STS_OK;
               rsp_w1_ff  <= '0;
               rsp_w2_ff  <= '0;
               rsp_w3_ff  <= '0;
               rsp_rb_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_tuser = rsp_sts_ff;
   assign rsp_tdata = {rsp_rb_ff, rsp_w3_ff, rsp_w2_ff, rsp_w1_ff};

endmodule

[sv/flash_iap_command_engine.sv]
// ----------------------------------------------------------------------------
// flash_iap_command_engine
// Flash and eeprom programming engine: streamed copy, compare and eeprom
// access, sector erase and blank check, and identification words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser action, tdata fields, tlast
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata words and byte
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// copy, compare and eeprom write beats are handled in the idle state; an eeprom
// read beat then loads its result from the registered eeprom read port.
// erase writes and blank check reads one byte of the range per step, through
// the flash write port and the flash read port respectively.
// after reset a clearing pass fills the flash with 0xFF and the eeprom with
// zero; no beat is accepted during it.
// a new beat is taken while a result waits, as long as that result leaves
// the output register in the same cycle or the register is empty.
module flash_iap_command_engine (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [3:0]   req_tuser,   // action
   // target_offset, byte_count, first_sector, final_sector, data_byte, other_byte
   input  logic [143:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   // result_word1, result_word2, result_word3, read_byte
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import fiap_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   fiap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // stores and result register
   fiap_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
